/* src/pid_pkg.sv */
package pid_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INTEGRAL_WIDTH = 48;
    localparam int WIDE_W = 64;
    localparam int CNT_W = 7;

    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_TARGET     = 3'd3;
    localparam logic [2:0] REG_LIMIT_LOW  = 3'd4;
    localparam logic [2:0] REG_LIMIT_HIGH = 3'd5;
    localparam logic [2:0] REG_WRAP_ON    = 3'd6;
    localparam logic [2:0] REG_WRAP_SPAN  = 3'd7;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CLAMP_LOW  = 2'd2;

    localparam logic [23:0] DT_DEFAULT = 24'(((1 << FRAC_BITS) + 500) / 1000);

    localparam logic signed [WIDE_W-1:0] TERM_SAT = 64'sd1 <<< 61;

    typedef struct packed {
        logic signed [31:0] measurement;
        logic [23:0]        time_step;
        logic               restart;
    } t_in;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [1:0]         clamp_state;
    } t_out;

    // unit opcodes
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_MOD
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR_MOD,
        S_ERR_FIX,
        S_P_MUL,
        S_P_DONE,
        S_STEP_MUL,
        S_STEP_DONE,
        S_I_MUL,
        S_I_DONE,
        S_D_MOD,
        S_D_FIX,
        S_D_DIV,
        S_D_DIVDONE,
        S_D_MUL,
        S_D_DONE,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                     start;
        t_op                      op;
        logic [WIDE_W-1:0]        a;
        logic [WIDE_W-1:0]        b;
    } t_unit_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [WIDE_W-1:0]        res;
        logic [WIDE_W-1:0]        hi;
    } t_unit_rsp;

endpackage

/* src/pid_serial_unit.sv */
// Shared bit-serial unit: unsigned multiply (shift-add), divide and modulo
// (restoring). One bit per cycle.
module pid_serial_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pid_pkg::t_unit_req   i_req,
    output pid_pkg::t_unit_rsp   o_rsp
);

    logic [pid_pkg::WIDE_W-1:0] r_a, n_a;
    logic [pid_pkg::WIDE_W-1:0] r_b, n_b;
    logic [pid_pkg::WIDE_W-1:0] r_acc, n_acc;
    logic [pid_pkg::WIDE_W:0]   r_rem, n_rem;
    logic [pid_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    pid_pkg::t_op               r_op, n_op;
    logic [pid_pkg::WIDE_W:0]   sum;
    logic [pid_pkg::WIDE_W:0]   shl;
    logic [pid_pkg::WIDE_W:0]   sub;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_op   = r_op;
        n_done = 1'b0;
        sum    = {1'b0, r_rem[pid_pkg::WIDE_W-1:0]} + (r_a[0] ? {1'b0, r_b} : '0);
        shl    = {r_rem[pid_pkg::WIDE_W-1:0], r_a[pid_pkg::WIDE_W-1]};
        sub    = shl - {1'b0, r_b};
        if (i_req.start && !r_busy) begin
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
            n_op   = i_req.op;
        end else if (r_busy) begin
            if (r_op == pid_pkg::OP_MUL) begin
                // rem holds high half, acc the low half shifting in from top
                n_rem = {1'b0, sum[pid_pkg::WIDE_W:1]};
                n_acc = {sum[0], r_acc[pid_pkg::WIDE_W-1:1]};
                n_a   = r_a >> 1;
            end else begin
                n_a = {r_a[pid_pkg::WIDE_W-2:0], 1'b0};
                if (!sub[pid_pkg::WIDE_W]) begin
                    n_rem = sub;
                    n_acc = {r_acc[pid_pkg::WIDE_W-2:0], 1'b1};
                end else begin
                    n_rem = shl;
                    n_acc = {r_acc[pid_pkg::WIDE_W-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == pid_pkg::CNT_W'(pid_pkg::WIDE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_op  <= n_op;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_op == pid_pkg::OP_MOD ? r_rem[pid_pkg::WIDE_W-1:0] : r_acc;
    assign o_rsp.hi   = r_rem[pid_pkg::WIDE_W-1:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy)) else $error("busy and done together");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cnt == pid_pkg::CNT_W'(pid_pkg::WIDE_W))
        else $error("unit ended early");

endmodule

/* src/pid_controller_wrap_antiwindup_top.sv */
// The p, integral-step and integral products always run through the shared
// 1-bit/cycle unit; the error fold, delta fold, rate divide and d product add up to
// four more passes. One transaction in flight; a stalled output register holds
// the sum stage and so the input.
// Reset (i_rst_n low, synchronous): registers to defaults, integral and last
// measurement cleared, first-sample flag set.
module pid_controller_wrap_antiwindup_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pid_pkg::t_in      i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output pid_pkg::t_out     o_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int W = pid_pkg::WIDE_W;
    localparam int IW = pid_pkg::INTEGRAL_WIDTH;
    localparam int FB = pid_pkg::FRAC_BITS;

    logic signed [31:0] r_gain_p, r_gain_i, r_gain_d, r_target, r_lim_lo, r_lim_hi;
    logic               r_wrap_on;
    logic [30:0]        r_wrap_span;

    logic signed [IW-1:0] r_integ, n_integ;
    logic signed [IW-1:0] r_old, n_old;
    logic signed [31:0]   r_last, n_last;
    logic                 r_first, n_first;
    logic signed [31:0]   r_meas, n_meas;
    logic [23:0]          r_dt, n_dt;
    logic signed [33:0]   r_val, n_val;
    logic                 r_vneg, n_vneg;
    logic signed [W-1:0]  r_p, n_p, r_i, n_i, r_d, n_d;
    logic signed [32:0]   r_err, n_err;
    logic                 r_neg, n_neg;
    pid_pkg::t_state      r_state, n_state;
    logic                 r_ovalid, n_ovalid;
    pid_pkg::t_out        r_out, n_out;

    pid_pkg::t_unit_req   req;
    pid_pkg::t_unit_rsp   rsp;

    logic                 in_acc;
    logic signed [34:0]   fold_v;
    logic                 fold_need;
    logic [W-1:0]         mag_a;
    logic signed [W-1:0]  mq;
    logic [W-1:0]         rnd;
    logic signed [W-1:0]  stepv;
    logic signed [IW:0]   isum;
    logic signed [W+1:0]  tsum;
    logic signed [IW-1:0] imax, imin;
    logic signed [33:0]   rr;
    logic signed [34:0]   r2;

    pid_serial_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_target <= '0;
            r_lim_lo <= 32'sh8000_0000;
            r_lim_hi <= 32'sh7fff_ffff;
            r_wrap_on <= 1'b0;
            r_wrap_span <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pid_pkg::REG_GAIN_P:     r_gain_p <= i_cfg_data;
                pid_pkg::REG_GAIN_I:     r_gain_i <= i_cfg_data;
                pid_pkg::REG_GAIN_D:     r_gain_d <= i_cfg_data;
                pid_pkg::REG_TARGET:     r_target <= i_cfg_data;
                pid_pkg::REG_LIMIT_LOW:  r_lim_lo <= i_cfg_data;
                pid_pkg::REG_LIMIT_HIGH: r_lim_hi <= i_cfg_data;
                pid_pkg::REG_WRAP_ON:    r_wrap_on <= i_cfg_data[0];
                pid_pkg::REG_WRAP_SPAN:  r_wrap_span <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_stall = r_state != pid_pkg::S_IDLE;
    assign in_acc  = i_valid && !o_stall;
    assign imax = {1'b0, {(IW-1){1'b1}}};
    assign imin = {1'b1, {(IW-1){1'b0}}};

    always_comb begin
        n_state = r_state; n_integ = r_integ; n_old = r_old; n_last = r_last;
        n_first = r_first; n_meas = r_meas; n_dt = r_dt; n_val = r_val;
        n_vneg = r_vneg; n_p = r_p; n_i = r_i; n_d = r_d; n_err = r_err;
        n_neg = r_neg; n_ovalid = r_ovalid; n_out = r_out;
        req = '0;
        req.op = pid_pkg::OP_MUL;
        fold_v = '0; fold_need = 1'b0; mag_a = '0; mq = '0; rnd = '0;
        stepv = '0; isum = '0; tsum = '0; rr = '0; r2 = '0;

        if (r_ovalid && !i_stall) n_ovalid = 1'b0;

        // rounded, saturated result of the last multiply (sign in r_neg)
        rnd = rsp.res + (W'(1) << (FB - 1));
        if ((rsp.hi + W'(rnd < rsp.res)) >> (FB - 3) != '0) mq = pid_pkg::TERM_SAT;
        else begin
            mq = signed'(((rsp.hi + W'(rnd < rsp.res)) << (W - FB)) | (rnd >> FB));
            if (mq > pid_pkg::TERM_SAT) mq = pid_pkg::TERM_SAT;
        end
        if (r_neg) mq = -mq;

        fold_need = r_wrap_on && r_wrap_span != '0 &&
            ((35'(r_val) <<< 1) > $signed({4'b0, r_wrap_span}) ||
             (35'(r_val) <<< 1) < -$signed({4'b0, r_wrap_span}));
        mag_a = r_val[33] ? W'(-r_val) : W'(r_val);

        unique case (r_state)
            pid_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_meas = i_data.measurement;
                    n_dt = i_data.time_step == '0 ? pid_pkg::DT_DEFAULT : i_data.time_step;
                    if (i_data.restart) begin
                        n_integ = '0; n_last = '0; n_first = 1'b1;
                    end
                    n_val = 34'(r_target) - 34'(i_data.measurement);
                    n_state = pid_pkg::S_ERR_MOD;
                end
            end
            pid_pkg::S_ERR_MOD, pid_pkg::S_D_MOD: begin
                if (!fold_need) begin
                    n_err = r_val[32:0];
                    n_state = r_state == pid_pkg::S_ERR_MOD ? pid_pkg::S_P_MUL
                                                            : pid_pkg::S_D_DIV;
                end else begin
                    req.start = 1'b1; req.op = pid_pkg::OP_MOD;
                    req.a = mag_a; req.b = W'(r_wrap_span);
                    if (rsp.done) begin
                        n_state = r_state == pid_pkg::S_ERR_MOD ? pid_pkg::S_ERR_FIX
                                                                : pid_pkg::S_D_FIX;
                        req.start = 1'b0;
                    end
                end
            end
            pid_pkg::S_ERR_FIX, pid_pkg::S_D_FIX: begin
                rr = 34'(rsp.res);
                if (r_val[33] && rr != '0) rr = 34'(r_wrap_span) - rr;
                r2 = 35'(rr) <<< 1;
                if (!r_val[33]) begin
                    if (r2 > 35'(r_wrap_span)) rr = rr - 34'(r_wrap_span);
                end else if (r2 >= 35'(r_wrap_span)) rr = rr - 34'(r_wrap_span);
                n_err = rr[32:0];
                n_state = r_state == pid_pkg::S_ERR_FIX ? pid_pkg::S_P_MUL
                                                        : pid_pkg::S_D_DIV;
            end
            pid_pkg::S_P_MUL: begin
                req.start = 1'b1;
                req.a = r_err[32] ? W'(-r_err) : W'(r_err);
                req.b = r_gain_p[31] ? W'(-33'(r_gain_p)) : W'(r_gain_p);
                n_neg = (r_err[32] != r_gain_p[31]) && r_err != '0 && r_gain_p != '0;
                if (rsp.done) begin req.start = 1'b0; n_state = pid_pkg::S_P_DONE; end
            end
            pid_pkg::S_P_DONE: begin
                n_p = mq;
                n_state = pid_pkg::S_STEP_MUL;
            end
            pid_pkg::S_STEP_MUL: begin
                req.start = 1'b1;
                req.a = r_err[32] ? W'(-r_err) : W'(r_err);
                req.b = W'(r_dt);
                n_neg = r_err[32];
                if (rsp.done) begin req.start = 1'b0; n_state = pid_pkg::S_STEP_DONE; end
            end
            pid_pkg::S_STEP_DONE: begin
                stepv = mq;
                n_old = r_integ;
                isum = (IW+1)'(r_integ) + (IW+1)'(stepv);
                if (stepv > 0 && W'(r_integ) > W'(imax) - stepv) n_integ = imax;
                else if (stepv < 0 && W'(r_integ) < W'(imin) - stepv) n_integ = imin;
                else n_integ = isum[IW-1:0];
                n_state = pid_pkg::S_I_MUL;
            end
            pid_pkg::S_I_MUL: begin
                req.start = 1'b1;
                req.a = r_integ[IW-1] ? W'(-(IW+1)'(r_integ)) : W'(r_integ);
                req.b = r_gain_i[31] ? W'(-33'(r_gain_i)) : W'(r_gain_i);
                n_neg = (r_integ[IW-1] != r_gain_i[31]);
                if (rsp.done) begin req.start = 1'b0; n_state = pid_pkg::S_I_DONE; end
            end
            pid_pkg::S_I_DONE: begin
                n_i = mq;
                n_d = '0;
                if (r_first) n_state = pid_pkg::S_SUM;
                else begin
                    n_val = 34'(r_meas) - 34'(r_last);
                    n_state = pid_pkg::S_D_MOD;
                end
            end
            pid_pkg::S_D_DIV: begin
                req.start = 1'b1; req.op = pid_pkg::OP_DIV;
                req.a = ((r_err[32] ? W'(-r_err) : W'(r_err)) << FB) + W'(r_dt >> 1);
                req.b = W'(r_dt);
                n_vneg = r_err[32];
                if (rsp.done) begin req.start = 1'b0; n_state = pid_pkg::S_D_DIVDONE; end
            end
            pid_pkg::S_D_DIVDONE: begin
                // rate magnitude parked in r_d until the d product is done
                n_d = signed'(rsp.res);
                n_state = pid_pkg::S_D_MUL;
            end
            pid_pkg::S_D_MUL: begin
                req.start = 1'b1;
                req.a = r_d;
                req.b = r_gain_d[31] ? W'(-33'(r_gain_d)) : W'(r_gain_d);
                n_neg = (r_vneg != r_gain_d[31]) && r_d != '0;
                if (rsp.done) begin req.start = 1'b0; n_state = pid_pkg::S_D_DONE; end
            end
            pid_pkg::S_D_DONE: begin
                n_d = -mq;
                n_state = pid_pkg::S_SUM;
            end
            pid_pkg::S_SUM: begin
                if (!r_ovalid || !i_stall) begin
                    tsum = (W+2)'(r_p) + (W+2)'(r_i) + (W+2)'(r_d);
                    n_out.clamp_state = pid_pkg::CLAMP_NONE;
                    n_out.drive = tsum[31:0];
                    if (tsum > (W+2)'(r_lim_hi)) begin
                        n_out.drive = r_lim_hi; n_out.clamp_state = pid_pkg::CLAMP_HIGH;
                    end else if (tsum < (W+2)'(r_lim_lo)) begin
                        n_out.drive = r_lim_lo; n_out.clamp_state = pid_pkg::CLAMP_LOW;
                    end
                    if (n_out.clamp_state != pid_pkg::CLAMP_NONE && r_gain_i != '0)
                        n_integ = r_old;
                    n_last = r_meas;
                    n_first = 1'b0;
                    n_ovalid = 1'b1;
                    n_state = pid_pkg::S_IDLE;
                end
            end
            default: n_state = pid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pid_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_integ <= '0;
            r_last <= '0;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_integ <= n_integ;
            r_last <= n_last;
            r_first <= n_first;
        end
        r_old <= n_old; r_meas <= n_meas; r_dt <= n_dt; r_val <= n_val;
        r_vneg <= n_vneg; r_p <= n_p; r_i <= n_i; r_d <= n_d; r_err <= n_err;
        r_neg <= n_neg; r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_dt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pid_pkg::S_D_DIV |-> r_dt != '0) else $error("zero dt in divide");
    a_first_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> !r_first) else $error("first flag not cleared");
    a_clamp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_out.clamp_state != 2'd3) else $error("bad clamp code");

endmodule
